>>> hw/rtl/visibility_cost_cell_macros.svh
// Assertion helpers shared by the RTL.
`ifndef VISIBILITY_COST_CELL_MACROS_SVH
`define VISIBILITY_COST_CELL_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define VCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define VCC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/vcc_pkg.sv
`default_nettype none
package vcc_pkg;

  localparam int unsigned MaxRadius    = 127;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned IdxW         = 5;

  localparam logic [15:0] RadiusReset = 16'd1280;
  localparam logic [15:0] StepReset   = 16'd13107;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  localparam logic signed [33:0] InvGain = 34'sd652032874;
  localparam logic signed [25:0] HalfPi  = 26'sd8388608;
  localparam logic signed [25:0] Pi      = 26'sd16777216;

  // atan(2^-i) with pi = 2^24
  function automatic logic signed [25:0] atan_val(input logic [IdxW-1:0] i);
    logic signed [25:0] r;
    case (i)
      5'd0:  r = 26'sd4194304;
      5'd1:  r = 26'sd2476042;
      5'd2:  r = 26'sd1308273;
      5'd3:  r = 26'sd664100;
      5'd4:  r = 26'sd333339;
      5'd5:  r = 26'sd166832;
      5'd6:  r = 26'sd83436;
      5'd7:  r = 26'sd41721;
      5'd8:  r = 26'sd20861;
      5'd9:  r = 26'sd10430;
      5'd10: r = 26'sd5215;
      5'd11: r = 26'sd2608;
      5'd12: r = 26'sd1304;
      5'd13: r = 26'sd652;
      5'd14: r = 26'sd326;
      5'd15: r = 26'sd163;
      5'd16: r = 26'sd81;
      5'd17: r = 26'sd41;
      5'd18: r = 26'sd20;
      5'd19: r = 26'sd10;
      5'd20: r = 26'sd5;
      5'd21: r = 26'sd3;
      5'd22: r = 26'sd1;
      5'd23: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // One slot of the CORDIC chain: angle vectoring plus two cosine rotations.
  typedef struct packed {
    logic                vld;
    logic                region;
    logic                centre;
    logic                neg_x;
    logic                neg_y;
    logic                zero_x;
    logic                zero_y;
    logic signed [33:0]  vx;
    logic signed [33:0]  vy;
    logic signed [25:0]  vz;
    logic signed [33:0]  cxx;
    logic signed [33:0]  cxy;
    logic signed [25:0]  cxz;
    logic signed [33:0]  cyx;
    logic signed [33:0]  cyy;
    logic signed [25:0]  cyz;
  } vcc_slot_t;

endpackage
`default_nettype wire

>>> hw/rtl/vcc_if.sv
`default_nettype none
interface vcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  cell_x;
  logic signed [7:0]  cell_y;
  logic signed [15:0] gaze_x;
  logic signed [15:0] gaze_y;
  modport source (output valid, cell_x, cell_y, gaze_x, gaze_y, input ready);
  modport sink   (input valid, cell_x, cell_y, gaze_x, gaze_y, output ready);
endinterface

interface vcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cost;
  logic       in_region;
  modport source (output valid, cost, in_region, input ready);
  modport sink   (input valid, cost, in_region, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/vcc_front.sv
`default_nettype none
module vcc_front
  import vcc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic signed [7:0]  cell_x_i,
  input  wire logic signed [7:0]  cell_y_i,
  input  wire logic signed [15:0] gaze_x_i,
  input  wire logic signed [15:0] gaze_y_i,
  input  wire logic [15:0]        radius_i,
  input  wire logic [15:0]        step_i,
  output vcc_slot_t               slot_o
);

  typedef struct packed {
    logic               vld;
    logic               centre;
    logic               gz;
    logic               over;
    logic [31:0]        d2;
    logic [31:0]        rr;
    logic signed [23:0] gxcx;
    logic signed [23:0] gycy;
    logic signed [23:0] gxcy;
    logic signed [23:0] gycx;
    logic [23:0]        sx;
    logic [23:0]        sy;
  } prod_t;

  prod_t     a_d, a_q;
  vcc_slot_t b_d, b_q;

  logic [7:0] ax, ay;

  // stage A: products
  always_comb begin
    ax = cell_x_i[7] ? 8'(-cell_x_i) : 8'(cell_x_i);
    ay = cell_y_i[7] ? 8'(-cell_y_i) : 8'(cell_y_i);
    a_d.vld    = vld_i;
    a_d.centre = (cell_x_i == 8'sd0) && (cell_y_i == 8'sd0);
    a_d.gz     = (gaze_x_i != 16'sd0) || (gaze_y_i != 16'sd0);
    a_d.over   = (ax > 8'(MaxRadius)) || (ay > 8'(MaxRadius));
    a_d.d2     = {16'(({8'd0, ax} * {8'd0, ax}) + ({8'd0, ay} * {8'd0, ay})), 16'd0};
    a_d.rr     = {16'd0, radius_i} * {16'd0, radius_i};
    a_d.gxcx   = 24'(gaze_x_i * cell_x_i);
    a_d.gycy   = 24'(gaze_y_i * cell_y_i);
    a_d.gxcy   = 24'(gaze_x_i * cell_y_i);
    a_d.gycx   = 24'(gaze_y_i * cell_x_i);
    a_d.sx     = {8'd0, step_i} * {16'd0, ax};
    a_d.sy     = {8'd0, step_i} * {16'd0, ay};
  end

  function automatic logic [25:0] fold(input logic [23:0] s);
    logic [24:0] p, p1;
    logic        neg;
    p   = {s[16:0], 8'd0};
    p1  = (p > 25'd16777216) ? 25'(26'd33554432 - {1'b0, p}) : p;
    neg = p1 > 25'd8388608;
    if (neg) p1 = 25'd16777216 - p1;
    return {(p == 25'd0), neg, p1[23:0]};
  endfunction

  logic signed [24:0] dot, cr;
  logic [24:0]        crm, ny, orv;
  logic [4:0]         blen;
  logic [4:0]         sh;
  logic [25:0]        fx, fy;
  logic               in_rad;

  // stage B: combine, normalize, fold phases
  always_comb begin
    dot  = 25'(a_q.gxcx) + 25'(a_q.gycy);
    cr   = 25'(a_q.gxcy) - 25'(a_q.gycx);
    crm  = cr[24] ? 25'(-cr) : 25'(cr);
    ny   = 25'(-dot);
    orv  = crm | ny;
    blen = 5'd0;
    for (int i = 0; i < 25; i++) begin
      if (orv[i]) blen = 5'(i + 1);
    end
    sh     = 5'(5'd30 - blen);
    in_rad = !a_q.over && (a_q.d2 <= a_q.rr);
    fx     = fold(a_q.sx);
    fy     = fold(a_q.sy);

    b_d.vld    = a_q.vld;
    b_d.region = in_rad && (a_q.centre || (a_q.gz && (dot <= 25'sd0)));
    b_d.centre = a_q.centre;
    b_d.vx     = $signed({9'd0, crm} << sh);
    b_d.vy     = $signed({9'd0, ny} << sh);
    b_d.vz     = 26'sd0;
    b_d.zero_x = fx[25];
    b_d.neg_x  = fx[24];
    b_d.cxx    = InvGain;
    b_d.cxy    = 34'sd0;
    b_d.cxz    = $signed({2'd0, fx[23:0]});
    b_d.zero_y = fy[25];
    b_d.neg_y  = fy[24];
    b_d.cyx    = InvGain;
    b_d.cyy    = 34'sd0;
    b_d.cyz    = $signed({2'd0, fy[23:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign slot_o = b_q;

endmodule
`default_nettype wire

>>> hw/rtl/vcc_cell.sv
`default_nettype none
module vcc_cell
  import vcc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  vcc_slot_t            slot_i,
  output vcc_slot_t            slot_o
);

  vcc_slot_t          s_d, s_q;
  logic signed [25:0] at;

  always_comb begin
    at  = atan_val(idx_i);
    s_d = slot_i;
    // vectoring: drive vy to zero
    if (slot_i.vy >= 34'sd0) begin
      s_d.vx = slot_i.vx + (slot_i.vy >>> idx_i);
      s_d.vy = slot_i.vy - (slot_i.vx >>> idx_i);
      s_d.vz = slot_i.vz + at;
    end else begin
      s_d.vx = slot_i.vx - (slot_i.vy >>> idx_i);
      s_d.vy = slot_i.vy + (slot_i.vx >>> idx_i);
      s_d.vz = slot_i.vz - at;
    end
    // rotations: drive z to zero
    if (slot_i.cxz >= 26'sd0) begin
      s_d.cxx = slot_i.cxx - (slot_i.cxy >>> idx_i);
      s_d.cxy = slot_i.cxy + (slot_i.cxx >>> idx_i);
      s_d.cxz = slot_i.cxz - at;
    end else begin
      s_d.cxx = slot_i.cxx + (slot_i.cxy >>> idx_i);
      s_d.cxy = slot_i.cxy - (slot_i.cxx >>> idx_i);
      s_d.cxz = slot_i.cxz + at;
    end
    if (slot_i.cyz >= 26'sd0) begin
      s_d.cyx = slot_i.cyx - (slot_i.cyy >>> idx_i);
      s_d.cyy = slot_i.cyy + (slot_i.cyx >>> idx_i);
      s_d.cyz = slot_i.cyz - at;
    end else begin
      s_d.cyx = slot_i.cyx + (slot_i.cyy >>> idx_i);
      s_d.cyy = slot_i.cyy - (slot_i.cyx >>> idx_i);
      s_d.cyz = slot_i.cyz + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (en_i) begin
      s_q <= s_d;
    end
  end

  assign slot_o = s_q;

endmodule
`default_nettype wire

>>> hw/rtl/vcc_back.sv
`default_nettype none
module vcc_back
  import vcc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  vcc_slot_t       slot_i,
  output logic            vld_o,
  output logic [7:0]      cost_o,
  output logic            region_o
);

  // cos+1 in Q16, up to 2.0 (bit 17 set)
  function automatic logic [17:0] cos_q16(input logic zero, input logic neg,
                                          input logic signed [33:0] x);
    logic signed [33:0] c;
    c = 34'sd1073741824 + (neg ? -x : x);
    if (zero) c = 34'sd2147483648;
    if (c < 34'sd0) c = 34'sd0;
    if (c > 34'sd2147483648) c = 34'sd2147483648;
    return c[31:14];
  endfunction

  logic               p_vld_q, p_reg_q, m_vld_q, m_reg_q, o_vld_q, o_reg_q;
  logic [24:0]        ang_d, ang_q;
  logic [26:0]        p24_d, p24_q;
  logic [50:0]        m_q;
  logic [17:0]        fx, fy;
  logic [35:0]        pp;
  logic signed [25:0] z;
  logic [58:0]        w;
  logic [7:0]         cost_d, cost_q;

  always_comb begin
    fx    = cos_q16(slot_i.zero_x, slot_i.neg_x, slot_i.cxx);
    fy    = cos_q16(slot_i.zero_y, slot_i.neg_y, slot_i.cyx);
    pp    = fx * fy;
    p24_d = pp[34:8];
    z     = slot_i.vz + HalfPi;
    if (z < HalfPi || slot_i.centre) z = HalfPi;
    if (z > Pi) z = Pi;
    ang_d = z[24:0];
    w     = ({8'd0, m_q} << 8) - {8'd0, m_q} + (59'd1 << 49);
    cost_d = (w[58:50] > 9'd255) ? 8'd255 : w[57:50];
    if (!m_reg_q) cost_d = 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      p_reg_q <= 1'b0;
      m_vld_q <= 1'b0;
      m_reg_q <= 1'b0;
      o_vld_q <= 1'b0;
      o_reg_q <= 1'b0;
      ang_q   <= '0;
      p24_q   <= '0;
      m_q     <= '0;
      cost_q  <= '0;
    end else if (en_i) begin
      p_vld_q <= slot_i.vld;
      p_reg_q <= slot_i.region;
      ang_q   <= ang_d;
      p24_q   <= p24_d;
      m_vld_q <= p_vld_q;
      m_reg_q <= p_reg_q;
      m_q     <= ang_q * p24_q;
      o_vld_q <= m_vld_q;
      o_reg_q <= m_reg_q;
      cost_q  <= cost_d;
    end
  end

  assign vld_o    = o_vld_q;
  assign cost_o   = cost_q;
  assign region_o = o_reg_q;

endmodule
`default_nettype wire

>>> hw/rtl/visibility_cost_cell.sv
// An input beat passes the front, the row of CORDIC cells and the back registers before it becomes a result beat.
// Throughput: one beat per cycle; the whole row of CORDIC cells advances together
// and holds only while the output register is full and not taken.
// Reset (rst_ni low, async): pipeline emptied, radius = 1280 (5 cells in Q8.8), phase_step = 13107.
`default_nettype none
`include "visibility_cost_cell_macros.svh"
module visibility_cost_cell
  import vcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  vcc_in_if.sink           item_i,
  vcc_out_if.source        result_o
);

  // Config registers; software must write them only while the pipe is idle; the block does not enforce this.
  logic [15:0] radius_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      step_q   <= StepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_STEP:   step_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Global advance: everything moves unless the result beat is stuck.
  logic en;
  logic out_vld;
  assign en           = !out_vld || result_o.ready;
  assign item_i.ready = en;

  vcc_slot_t chain [CordicStages+1];

  // Front: products, radius test, dot/cross, normalize, phase folding.
  vcc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (item_i.valid),
    .cell_x_i (item_i.cell_x),
    .cell_y_i (item_i.cell_y),
    .gaze_x_i (item_i.gaze_x),
    .gaze_y_i (item_i.gaze_y),
    .radius_i (radius_q),
    .step_i   (step_q),
    .slot_o   (chain[0])
  );

  // Row of CORDIC cells: cell i performs micro-rotation i of all three units.
  for (genvar i = 0; i < CordicStages; i++) begin : g_cell
    vcc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (IdxW'(i)),
      .slot_i (chain[i]),
      .slot_o (chain[i+1])
    );
  end

  // Back: cos+1 scaling, product, angle weight, round and clamp.
  vcc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .slot_i   (chain[CordicStages]),
    .vld_o    (out_vld),
    .cost_o   (result_o.cost),
    .region_o (result_o.in_region)
  );

  assign result_o.valid = out_vld;

  `VCC_ASSERT(a_zero_outside, out_vld && !result_o.in_region |-> result_o.cost == 8'd0, "cost outside region")
  `VCC_ASSERT(a_stall_in, out_vld && !result_o.ready |-> !item_i.ready, "input taken during stall")
  `VCC_ASSERT(a_hold_out, out_vld && !result_o.ready |=> out_vld && $stable(result_o.cost), "beat dropped")
  `VCC_NEVER(a_ready_x, $isunknown(item_i.ready), "ready unknown")

endmodule
`default_nettype wire

>>> tb/tb_visibility_cost_cell.sv
`default_nettype none
module tb_visibility_cost_cell;
  import vcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 4000;  // cycles without any beat before giving up
  localparam int DrainWait  = 30;    // settle time after the expected queue has emptied

  // atan(2^-i) with pi = 2^24, own copy for the cost predictor
  localparam longint AtanTab [24] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1};
  localparam longint AngPi     = 64'd1 << 24;
  localparam longint AngHalfPi = 64'd1 << 23;

  typedef struct {
    logic [7:0] cost;
    logic       in_region;
  } cost_beat_t;

  typedef struct {
    logic signed [7:0]  cx;
    logic signed [7:0]  cy;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    bit                 typed;   // expected value given below, not predicted
    logic [7:0]         cost;
    logic               in_region;
  } cell_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  vcc_in_if  cell_if ();
  vcc_out_if cost_if ();

  visibility_cost_cell DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (cell_if.sink),
    .result_o   (cost_if.source)
  );

  // shadow of the block's registers
  logic [15:0] radius_q8;
  logic [15:0] step_q16;

  cost_beat_t cost_fifo[$];
  int errors;
  int cells_sent;
  int costs_seen;
  int region_hits;
  int quiet_cycles;
  int gap_pct;     // sender idle chance, percent
  int stall_pct;   // receiver stall chance, percent

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Cost predictor
  // ---------------------------------------------------------------------------

  // (cos(step*n*pi) + 1) in Q30
  function automatic longint cos_plus_one(longint step, longint n);
    longint p, x, y, z, xs, ys, c;
    bit neg;
    p = (step * n * 256) & ((64'd1 << 25) - 1);
    neg = 1'b0;
    if (p == 0) return 64'd1 << 31;
    if (p > AngPi) p = (64'd1 << 25) - p;
    if (p > AngHalfPi) begin
      neg = 1'b1;
      p = AngPi - p;
    end
    x = 652032874;
    y = 0;
    z = p;
    for (int i = 0; i < CordicStages && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= AtanTab[i];
      end else begin
        x = x + ys; y = y - xs; z += AtanTab[i];
      end
    end
    c = (64'd1 << 30) + (neg ? -x : x);
    if (c < 0) c = 0;
    if (c > (64'd1 << 31)) c = 64'd1 << 31;
    return c;
  endfunction

  // pi/2 + atan2(ny, cr), both non-negative
  function automatic longint rear_angle(longint cr, longint ny);
    longint x, y, z, xs, ys;
    int guard;
    x = cr;
    y = ny;
    z = 0;
    guard = 0;
    // normalize so the vectoring keeps its precision
    while (x < (64'd1 << 29) && y < (64'd1 << 29) && guard < 40) begin
      x *= 2; y *= 2; guard++;
    end
    for (int i = 0; i < CordicStages && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += AtanTab[i];
      end else begin
        x = x - ys; y = y + xs; z -= AtanTab[i];
      end
    end
    z += AngHalfPi;
    if (z < AngHalfPi) z = AngHalfPi;
    if (z > AngPi) z = AngPi;
    return z;
  endfunction

  function automatic cost_beat_t predict_cost(logic signed [7:0] cx8, logic signed [7:0] cy8,
                                              logic signed [15:0] gx16,
                                              logic signed [15:0] gy16);
    cost_beat_t r;
    longint cx, cy, gx, gy, ax, ay, d2, rad, dot, cr, angle;
    longint unsigned fx, fy, p24, c;
    bit in_rad, region;
    cx = cx8; cy = cy8; gx = gx16; gy = gy16;
    ax = cx < 0 ? -cx : cx;
    ay = cy < 0 ? -cy : cy;
    d2 = (ax * ax + ay * ay) << 16;
    rad = radius_q8;
    region = 1'b0;
    angle = AngHalfPi;
    in_rad = ax <= MaxRadius && ay <= MaxRadius && d2 <= rad * rad;
    if (in_rad) begin
      if (cx == 0 && cy == 0) begin
        region = 1'b1;   // centre cell: angle fixed at pi/2
      end else if (gx != 0 || gy != 0) begin
        dot = gx * cx + gy * cy;
        cr = gx * cy - gy * cx;
        if (dot <= 0) begin
          region = 1'b1;
          angle = rear_angle(cr < 0 ? -cr : cr, -dot);
        end
      end
    end
    c = 0;
    if (region) begin
      fx = cos_plus_one(step_q16, ax) >> 14;
      fy = cos_plus_one(step_q16, ay) >> 14;
      p24 = (fx * fy) >> 8;
      c = (longint'(angle) * p24 * 255 + (64'd1 << 49)) >> 50;
      if (c > 255) c = 255;
    end
    r.cost = c[7:0];
    r.in_region = region;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("%0t ns MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  // result side: random stalls driven at the falling edge
  initial cost_if.ready = 1'b0;
  always @(negedge clk_i) begin
    cost_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // result beats compared against the oldest expected cost
  always @(posedge clk_i) begin
    cost_beat_t want;
    if (rst_ni && cost_if.valid && cost_if.ready) begin
      costs_seen++;
      if (cost_if.in_region) region_hits++;
      if (cost_fifo.size() == 0) begin
        report_mismatch($sformatf("unexpected beat cost=%0d in_region=%0b",
                                  cost_if.cost, cost_if.in_region));
      end else begin
        want = cost_fifo.pop_front();
        if (cost_if.cost !== want.cost)
          report_mismatch($sformatf("cost %0d, expected %0d", cost_if.cost, want.cost));
        if (cost_if.in_region !== want.in_region)
          report_mismatch($sformatf("in_region %0b, expected %0b",
                                    cost_if.in_region, want.in_region));
      end
    end
  end

  // watchdog: only cycles with no beat on either side count
  always @(posedge clk_i) begin
    if ((cell_if.valid && cell_if.ready) || (cost_if.valid && cost_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: %0d cycles without a beat", QuietLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // one cell beat, held until taken; the expected cost is queued on acceptance
  task automatic send_cell(logic signed [7:0] cx, logic signed [7:0] cy,
                           logic signed [15:0] gx, logic signed [15:0] gy,
                           bit typed, cost_beat_t typed_exp);
    cost_beat_t want;
    want = typed ? typed_exp : predict_cost(cx, cy, gx, gy);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      cell_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cell_if.valid  <= 1'b1;
    cell_if.cell_x <= cx;
    cell_if.cell_y <= cy;
    cell_if.gaze_x <= gx;
    cell_if.gaze_y <= gy;
    do @(posedge clk_i); while (!(cell_if.valid && cell_if.ready));
    cost_fifo.push_back(want);
    cells_sent++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RADIUS) radius_q8 = val;
    else step_q16 = val;
  endtask

  task automatic drain();
    @(negedge clk_i);
    cell_if.valid <= 1'b0;
    while (cost_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic random_cells(int count);
    int lim;
    logic signed [7:0] cx, cy;
    logic signed [15:0] gx, gy;
    cost_beat_t none;
    none = '{cost: 8'd0, in_region: 1'b0};
    lim = radius_q8 >> 8;
    if (lim > 127) lim = 127;
    for (int n = 0; n < count; n++) begin
      // mostly cells near the person, some anywhere in the byte range
      if ($urandom_range(99) < 80) begin
        cx = 8'($urandom_range(2 * lim) - lim);
        cy = 8'($urandom_range(2 * lim) - lim);
      end else begin
        cx = 8'($urandom);
        cy = 8'($urandom);
      end
      case ($urandom_range(9))
        0: begin gx = '0; gy = '0; end
        1: begin gx = 16'($urandom); gy = '0; end
        2: begin gx = '0; gy = 16'($urandom); end
        3: begin
          gx = 16'($urandom_range(64) - 32);
          gy = 16'($urandom_range(64) - 32);
        end
        default: begin gx = 16'($urandom); gy = 16'($urandom); end
      endcase
      send_cell(cx, cy, gx, gy, 1'b0, none);
    end
  endtask

  // directed cells, default registers (radius 5 cells)
  cell_row_t corner_rows[] = '{
    '{  8'sd0,    8'sd0,    16'sd1000,   16'sd0,      1'b1, 8'd128, 1'b1},  // centre
    '{  8'sd0,    8'sd0,    16'sd0,      16'sd0,      1'b1, 8'd128, 1'b1},  // centre, no gaze
    '{  8'sd3,    8'sd0,    16'sd0,      16'sd0,      1'b1, 8'd0,   1'b0},  // no gaze
    '{ -8'sd128,  8'sd0,    -16'sd16384, 16'sd0,      1'b1, 8'd0,   1'b0},  // past max
    '{  8'sd0,   -8'sd128,  16'sd0,      16'sd16384,  1'b1, 8'd0,   1'b0},  // past max
    '{  8'sd127,  8'sd127,  -16'sd32768, -16'sd32768, 1'b1, 8'd0,   1'b0},  // past radius
    '{  8'sd6,    8'sd0,    -16'sd16384, 16'sd0,      1'b1, 8'd0,   1'b0},  // past radius
    '{  8'sd4,    8'sd3,    16'sd16384,  16'sd0,      1'b1, 8'd0,   1'b0},  // ahead of gaze
    '{  8'sd5,    8'sd0,    -16'sd16384, 16'sd0,      1'b0, 8'd0,   1'b0},  // straight behind
    '{  8'sd0,    8'sd5,    16'sd16384,  16'sd0,      1'b0, 8'd0,   1'b0},  // exactly beside
    '{  8'sd3,    8'sd4,    -16'sd32768, -16'sd32768, 1'b0, 8'd0,   1'b0},
    '{ -8'sd5,    8'sd0,    16'sd32767,  16'sd0,      1'b0, 8'd0,   1'b0},
    '{  8'sd1,    8'sd1,    16'sd32767,  -16'sd32768, 1'b0, 8'd0,   1'b0},
    '{ -8'sd1,   -8'sd1,    -16'sd1,     16'sd1,      1'b0, 8'd0,   1'b0},
    '{  8'sd2,   -8'sd3,    16'sd32767,  16'sd32767,  1'b0, 8'd0,   1'b0},
    '{ -8'sd2,    8'sd2,    16'sd1,      16'sd0,      1'b0, 8'd0,   1'b0},
    '{  8'sd0,   -8'sd4,    16'sd0,      16'sd1,      1'b0, 8'd0,   1'b0},
    '{ -8'sd3,   -8'sd4,    16'sd32767,  16'sd32767,  1'b0, 8'd0,   1'b0}
  };

  // per phase: radius, step; first phase keeps the reset values
  logic [15:0] phase_radius[6] = '{16'd1280, 16'd65535, 16'd0, 16'd32512, 16'd2560, 16'd20000};
  logic [15:0] phase_step[6]   = '{16'd13107, 16'd65535, 16'd0, 16'd516, 16'd6554, 16'd3277};

  initial begin
    cost_beat_t row_exp;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RADIUS;
    cfg_data_i    = '0;
    cell_if.valid  = 1'b0;
    cell_if.cell_x = '0;
    cell_if.cell_y = '0;
    cell_if.gaze_x = '0;
    cell_if.gaze_y = '0;
    radius_q8 = RadiusReset;
    step_q16  = StepReset;
    errors = 0;
    cells_sent = 0;
    costs_seen = 0;
    region_hits = 0;
    quiet_cycles = 0;
    gap_pct = 7;
    stall_pct = 75;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // phases 0-1: sparse sender gaps, heavy stalls; 2-3 the reverse; 4-5 full rate
    for (int ph = 0; ph < 6; ph++) begin
      gap_pct   = (ph < 2) ? 7 : (ph < 4) ? 75 : 0;
      stall_pct = (ph < 2) ? 75 : (ph < 4) ? 7 : 0;
      if (ph > 0) begin
        write_reg(REG_RADIUS, phase_radius[ph]);
        write_reg(REG_STEP, phase_step[ph]);
      end else begin
        foreach (corner_rows[i]) begin
          row_exp.cost = corner_rows[i].cost;
          row_exp.in_region = corner_rows[i].in_region;
          send_cell(corner_rows[i].cx, corner_rows[i].cy, corner_rows[i].gx,
                    corner_rows[i].gy, corner_rows[i].typed, row_exp);
        end
      end
      random_cells(150);
      drain();
    end

    $display("covered %0d cells over 6 register settings, %0d costs checked, %0d in region",
             cells_sent, costs_seen, region_hits);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
